### hw/rtl/token_lexer_stream_defines.svh
// Assertion helpers for the token scanner.
`ifndef TOKEN_LEXER_STREAM_DEFINES_SVH
`define TOKEN_LEXER_STREAM_DEFINES_SVH

// Check a property on every clock edge outside of reset.
`define TLS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`endif

### hw/rtl/tls_pkg.sv
package tls_pkg;

  localparam int unsigned KindW = 6;

  localparam logic [5:0] KLParen   = 6'd0;
  localparam logic [5:0] KRParen   = 6'd1;
  localparam logic [5:0] KLBracket = 6'd2;
  localparam logic [5:0] KRBracket = 6'd3;
  localparam logic [5:0] KLBrace   = 6'd4;
  localparam logic [5:0] KRBrace   = 6'd5;
  localparam logic [5:0] KSemi     = 6'd6;
  localparam logic [5:0] KComma    = 6'd7;
  localparam logic [5:0] KPlus     = 6'd8;
  localparam logic [5:0] KMinus    = 6'd9;
  localparam logic [5:0] KStar     = 6'd10;
  localparam logic [5:0] KSlash   = 6'd11;
  localparam logic [5:0] KPercent  = 6'd12;
  localparam logic [5:0] KBang    = 6'd13;
  localparam logic [5:0] KBangEq  = 6'd14;
  localparam logic [5:0] KDot     = 6'd15;
  localparam logic [5:0] KEq      = 6'd16;
  localparam logic [5:0] KEqEq    = 6'd17;
  localparam logic [5:0] KLess    = 6'd18;
  localparam logic [5:0] KLessEq  = 6'd19;
  localparam logic [5:0] KGreater = 6'd20;
  localparam logic [5:0] KGreatEq = 6'd21;
  localparam logic [5:0] KIdent   = 6'd22;
  localparam logic [5:0] KNumber  = 6'd23;
  localparam logic [5:0] KString  = 6'd24;
  localparam logic [5:0] KKwFirst = 6'd25;
  localparam logic [5:0] KError   = 6'd38;
  localparam logic [5:0] KEof     = 6'd39;

  // Scan modes.
  localparam logic [3:0] MdIdle    = 4'd0;
  localparam logic [3:0] MdComment = 4'd1;
  localparam logic [3:0] MdSlash   = 4'd2;
  localparam logic [3:0] MdOp      = 4'd3;
  localparam logic [3:0] MdIdent   = 4'd4;
  localparam logic [3:0] MdInt     = 4'd5;
  localparam logic [3:0] MdNumDot  = 4'd6;
  localparam logic [3:0] MdFrac    = 4'd7;
  localparam logic [3:0] MdDot     = 4'd8;
  localparam logic [3:0] MdStr     = 4'd9;

  // Keyword text, six bytes, first byte in the low bits, zero padded.
  localparam logic [47:0] KwText [13] = '{
    {8'h00, 8'h00, 8'h00, "d", "n", "a"},
    {8'h00, "s", "s", "a", "l", "c"},
    {8'h00, 8'h00, "e", "s", "l", "e"},
    {8'h00, "e", "s", "l", "a", "f"},
    {8'h00, 8'h00, 8'h00, "r", "o", "f"},
    {8'h00, 8'h00, 8'h00, "n", "u", "f"},
    {8'h00, 8'h00, 8'h00, 8'h00, "f", "i"},
    {8'h00, 8'h00, "l", "l", "u", "n"},
    {8'h00, 8'h00, 8'h00, 8'h00, "r", "o"},
    {"n", "r", "u", "t", "e", "r"},
    {8'h00, 8'h00, "e", "u", "r", "t"},
    {8'h00, 8'h00, 8'h00, "r", "a", "v"},
    {8'h00, "e", "l", "i", "h", "w"}
  };
  localparam logic [2:0] KwLen [13] = '{3'd3, 3'd5, 3'd4, 3'd5, 3'd3, 3'd3, 3'd2,
                                          3'd4, 3'd2, 3'd6, 3'd4, 3'd3, 3'd5};

  function automatic logic is_letter(input logic [7:0] c);
    is_letter = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_num(input logic [7:0] c);
    is_num = c >= "0" && c <= "9";
  endfunction

  function automatic logic [5:0] op_kind(input logic [7:0] c, input logic two);
    case (c)
      "!":     op_kind = two ? KBangEq : KBang;
      "=":     op_kind = two ? KEqEq : KEq;
      "<":     op_kind = two ? KLessEq : KLess;
      default: op_kind = two ? KGreatEq : KGreater;
    endcase
  endfunction

  // Single-byte token kind; error for anything unknown.
  function automatic logic [5:0] single_kind(input logic [7:0] c);
    case (c)
      "(":     single_kind = KLParen;
      ")":     single_kind = KRParen;
      "[":     single_kind = KLBracket;
      "]":     single_kind = KRBracket;
      "{":     single_kind = KLBrace;
      "}":     single_kind = KRBrace;
      ";":     single_kind = KSemi;
      ",":     single_kind = KComma;
      "+":     single_kind = KPlus;
      "-":     single_kind = KMinus;
      "*":     single_kind = KStar;
      "%":     single_kind = KPercent;
      default: single_kind = KError;
    endcase
  endfunction

endpackage

### hw/rtl/tls_front.sv
// Scanner front: runs the per-byte state machine and produces up to three
// tokens per byte as one bundle.
module tls_front #(
  parameter int unsigned KeywordMaxLen = 6,
  parameter int unsigned LengthBits    = 16,
  parameter int unsigned PositionBits  = 24
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  logic [7:0]              byte_i,
  input  logic                    end_i,
  output logic                    ready_o,
  input  logic                    q_ready_i,
  output logic                    q_valid_o,
  output logic [1:0]              q_count_o,
  output logic [3*tls_pkg::KindW-1:0] q_kind_o,
  output logic [3*PositionBits-1:0]   q_start_o,
  output logic [3*LengthBits-1:0]     q_len_o,
  output logic [3*PositionBits-1:0]   q_line_o
);
  localparam logic [PositionBits-1:0] PosMax = '1;
  localparam logic [LengthBits-1:0]   LenMax = '1;
  localparam int unsigned BufIdxW = $clog2(KeywordMaxLen);

  logic [3:0]              mode_q, mode_d;
  logic [7:0]              pend_q, pend_d;
  logic [7:0]              wbuf_q [KeywordMaxLen];
  logic                    wr_en;
  logic [BufIdxW-1:0]      wr_idx;
  logic [LengthBits-1:0]   run_q, run_d;
  logic [PositionBits-1:0] start_q, start_d, pos_q, pos_d, line_q, line_d;

  logic [1:0]              n;
  logic [tls_pkg::KindW-1:0] k [3];
  logic [PositionBits-1:0] s [3];
  logic [LengthBits-1:0]   l [3];
  logic [PositionBits-1:0] ln [3];

  logic fire;
  assign ready_o   = q_ready_i;
  assign fire      = valid_i && q_ready_i;
  assign q_valid_o = fire;
  assign q_count_o = n;

  function automatic logic [LengthBits-1:0] linc(input logic [LengthBits-1:0] v);
    linc = (v == LenMax) ? v : v + 1'b1;
  endfunction
  function automatic logic [PositionBits-1:0] pinc(input logic [PositionBits-1:0] v);
    pinc = (v == PosMax) ? v : v + 1'b1;
  endfunction

  // Keyword match against the buffered first bytes.
  logic [5:0] word_kind;
  always_comb begin
    logic hit;
    word_kind = tls_pkg::KIdent;
    for (int i = 12; i >= 0; i--) begin
      hit = (run_q == LengthBits'(tls_pkg::KwLen[i]));
      for (int j = 0; j < 6; j++) begin
        if (j < int'(tls_pkg::KwLen[i]) && wbuf_q[j] != tls_pkg::KwText[i][8*j +: 8])
          hit = 1'b0;
      end
      if (hit) word_kind = tls_pkg::KKwFirst + 6'(i);
    end
  end

  always_comb begin
    logic taken, ending;
    logic [PositionBits-1:0] dot_at, st;
    logic [LengthBits-1:0] run;
    logic [3:0] md;
    mode_d = mode_q; pend_d = pend_q; run_d = run_q; start_d = start_q;
    line_d = line_q; pos_d = pos_q;
    wr_en = 1'b0; wr_idx = '0;
    n = '0;
    for (int i = 0; i < 3; i++) begin
      k[i] = '0; s[i] = '0; l[i] = '0; ln[i] = line_q;
    end
    taken  = 1'b0;
    ending = end_i || byte_i == 8'h00;
    dot_at = (pos_q != '0) ? pos_q - 1'b1 : '0;
    md     = mode_q;
    run    = run_q;
    st     = start_q;

    if (!ending) begin
      case (mode_q)
        tls_pkg::MdComment: begin
          if (byte_i == 8'h0a) md = tls_pkg::MdIdle; else taken = 1'b1;
        end
        tls_pkg::MdSlash: begin
          if (byte_i == "/") begin md = tls_pkg::MdComment; taken = 1'b1; end
        end
        tls_pkg::MdOp: begin
          if (byte_i == "=") begin
            k[0] = tls_pkg::op_kind(pend_q, 1'b1); s[0] = st;
            l[0] = LengthBits'(2); n = 2'd1;
            md = tls_pkg::MdIdle; taken = 1'b1;
          end
        end
        tls_pkg::MdIdent: begin
          if (tls_pkg::is_letter(byte_i) || tls_pkg::is_num(byte_i)) begin
            if (run < LengthBits'(KeywordMaxLen)) begin
              wr_en = 1'b1; wr_idx = run[BufIdxW-1:0];
            end
            run = linc(run); taken = 1'b1;
          end
        end
        tls_pkg::MdInt: begin
          if (tls_pkg::is_num(byte_i)) begin run = linc(run); taken = 1'b1; end
          else if (byte_i == ".") begin md = tls_pkg::MdNumDot; taken = 1'b1; end
        end
        tls_pkg::MdNumDot: begin
          if (tls_pkg::is_num(byte_i)) begin
            run = linc(linc(run)); md = tls_pkg::MdFrac; taken = 1'b1;
          end
        end
        tls_pkg::MdFrac: begin
          if (tls_pkg::is_num(byte_i)) begin run = linc(run); taken = 1'b1; end
        end
        tls_pkg::MdDot: begin
          if (tls_pkg::is_num(byte_i)) begin
            run = linc(run); md = tls_pkg::MdInt; taken = 1'b1;
          end
        end
        tls_pkg::MdStr: begin
          run = linc(run);
          if (byte_i == 8'h22) begin
            k[0] = tls_pkg::KString; s[0] = st; l[0] = run; n = 2'd1;
            md = tls_pkg::MdIdle;
          end
          taken = 1'b1;
        end
        default: md = tls_pkg::MdIdle;
      endcase
    end

    // Flush the pending token when the byte does not extend it or the source ends.
    if (ending || !taken) begin
      case (md)
        tls_pkg::MdSlash: begin
          k[n] = tls_pkg::KSlash; s[n] = st; l[n] = LengthBits'(1); n = n + 2'd1;
        end
        tls_pkg::MdOp: begin
          k[n] = tls_pkg::op_kind(pend_q, 1'b0); s[n] = st; l[n] = LengthBits'(1);
          n = n + 2'd1;
        end
        tls_pkg::MdIdent: begin
          k[n] = word_kind; s[n] = st; l[n] = run; n = n + 2'd1;
        end
        tls_pkg::MdInt, tls_pkg::MdFrac: begin
          k[n] = tls_pkg::KNumber; s[n] = st; l[n] = run; n = n + 2'd1;
        end
        tls_pkg::MdNumDot: begin
          k[0] = tls_pkg::KNumber; s[0] = st; l[0] = run;
          k[1] = tls_pkg::KDot; s[1] = dot_at; l[1] = LengthBits'(1); n = 2'd2;
        end
        tls_pkg::MdDot: begin
          k[n] = tls_pkg::KDot; s[n] = st; l[n] = LengthBits'(1); n = n + 2'd1;
        end
        tls_pkg::MdStr: begin
          k[n] = tls_pkg::KError; s[n] = st; l[n] = run; n = n + 2'd1;
        end
        default: ;
      endcase
      md = tls_pkg::MdIdle;
    end

    if (ending) begin
      k[n] = tls_pkg::KEof; s[n] = pos_q; l[n] = '0; n = n + 2'd1;
      mode_d = tls_pkg::MdIdle; pend_d = '0; run_d = '0; start_d = '0;
      pos_d = '0; line_d = PositionBits'(1);
    end else begin
      if (!taken) begin
        // Start a new token at this byte.
        st = pos_q; run = LengthBits'(1);
        if (byte_i == " " || byte_i == 8'h0d || byte_i == 8'h09) begin
        end else if (byte_i == 8'h0a) begin
          line_d = pinc(line_q);
        end else if (tls_pkg::is_letter(byte_i)) begin
          wr_en = 1'b1; wr_idx = '0; md = tls_pkg::MdIdent;
        end else if (tls_pkg::is_num(byte_i)) begin
          md = tls_pkg::MdInt;
        end else if (byte_i == ".") begin
          md = tls_pkg::MdDot;
        end else if (byte_i == "/") begin
          md = tls_pkg::MdSlash;
        end else if (byte_i == 8'h22) begin
          md = tls_pkg::MdStr;
        end else if (byte_i == "!" || byte_i == "=" || byte_i == "<" || byte_i == ">") begin
          pend_d = byte_i; md = tls_pkg::MdOp;
        end else begin
          k[n] = tls_pkg::single_kind(byte_i); s[n] = pos_q; l[n] = LengthBits'(1);
          n = n + 2'd1;
        end
      end
      mode_d = md; run_d = run; start_d = st; pos_d = pinc(pos_q);
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_pack
    assign q_kind_o[i*tls_pkg::KindW +: tls_pkg::KindW] = k[i];
    assign q_start_o[i*PositionBits +: PositionBits]    = s[i];
    assign q_len_o[i*LengthBits +: LengthBits]          = l[i];
    assign q_line_o[i*PositionBits +: PositionBits]     = ln[i];
  end

  // Advance scan state on each accepted byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= tls_pkg::MdIdle;
      pend_q  <= '0;
      run_q   <= '0;
      start_q <= '0;
      pos_q   <= '0;
      line_q  <= PositionBits'(1);
    end else if (fire) begin
      mode_q  <= mode_d;
      pend_q  <= pend_d;
      run_q   <= run_d;
      start_q <= start_d;
      pos_q   <= pos_d;
      line_q  <= line_d;
    end
  end

  // Keyword buffer holds the first identifier bytes.
  always_ff @(posedge clk_i) begin
    if (fire && wr_en) wbuf_q[wr_idx] <= byte_i;
  end
endmodule

### hw/rtl/tls_back.sv
// Token queue and serializer: stores bundles of up to three tokens and
// hands them out one word at a time with a last flag.
module tls_back #(
  parameter int unsigned LengthBits   = 16,
  parameter int unsigned PositionBits = 24
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  logic [1:0]                  count_i,
  input  logic [3*tls_pkg::KindW-1:0] kind_i,
  input  logic [3*PositionBits-1:0]   start_i,
  input  logic [3*LengthBits-1:0]     len_i,
  input  logic [3*PositionBits-1:0]   line_i,
  output logic                        ready_o,
  output logic                        valid_o,
  input  logic                        ready_i,
  output logic [tls_pkg::KindW-1:0]   kind_o,
  output logic [PositionBits-1:0]     start_o,
  output logic [LengthBits-1:0]       len_o,
  output logic [PositionBits-1:0]     line_o,
  output logic                        last_o
);
  localparam int unsigned EntW = tls_pkg::KindW + 2*PositionBits + LengthBits;
  localparam int unsigned Depth = 8;
  localparam int unsigned AW = 3;

  logic [EntW-1:0] mem_q [Depth];
  logic [AW-1:0]   wp_q, rp_q;
  logic [AW:0]     cnt_q;
  logic            last_mem_q [Depth];
  logic            pop;

  assign ready_o = cnt_q <= (AW+1)'(Depth - 3);
  assign valid_o = cnt_q != '0;
  assign pop     = valid_o && ready_i;
  assign {kind_o, start_o, len_o, line_o} = mem_q[rp_q];
  assign last_o  = last_mem_q[rp_q];

  // Write up to three entries per push.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      if (push_i && 2'(i) < count_i) begin
        mem_q[wp_q + AW'(i)] <= {kind_i[i*tls_pkg::KindW +: tls_pkg::KindW],
                                 start_i[i*PositionBits +: PositionBits],
                                 len_i[i*LengthBits +: LengthBits],
                                 line_i[i*PositionBits +: PositionBits]};
        last_mem_q[wp_q + AW'(i)] <= (2'(i) == count_i - 2'd1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + AW'(count_i);
      if (pop) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (push_i ? (AW+1)'(count_i) : '0) - (AW+1)'(pop);
    end
  end
endmodule

### hw/rtl/token_lexer_stream.sv
// channel | valid        | ready        | payload
// in      | valid_i      | ready_o      | source_byte_i, end_of_source_i
// out     | valid_o      | ready_i      | token_kind_o .. last_o
//
// One source byte per cycle is accepted while the token queue has room for
// three more tokens; the scanner's next state is formed combinationally.
// Tokens leave one per cycle while ready_i is high, from an eight-entry queue.
// Reset is asynchronous; after it the line counter reads one.
`include "token_lexer_stream_defines.svh"
module token_lexer_stream #(
  parameter int unsigned KEYWORD_MAX_LEN = 6,
  parameter int unsigned LENGTH_BITS     = 16,
  parameter int unsigned POSITION_BITS   = 24
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     ready_o,
  input  logic [7:0]               source_byte_i,
  input  logic                     end_of_source_i,
  output logic                     valid_o,
  input  logic                     ready_i,
  output logic [5:0]               token_kind_o,
  output logic [POSITION_BITS-1:0] token_start_o,
  output logic [LENGTH_BITS-1:0]   token_length_o,
  output logic [POSITION_BITS-1:0] token_line_o,
  output logic                     last_o
);
  logic                        q_ready, q_valid;
  logic [1:0]                  q_count;
  logic [3*tls_pkg::KindW-1:0] q_kind;
  logic [3*POSITION_BITS-1:0]  q_start, q_line;
  logic [3*LENGTH_BITS-1:0]    q_len;

  tls_front #(
    .KeywordMaxLen(KEYWORD_MAX_LEN), .LengthBits(LENGTH_BITS),
    .PositionBits(POSITION_BITS)
  ) u_front (
    .clk_i, .rst_ni, .valid_i, .byte_i(source_byte_i), .end_i(end_of_source_i),
    .ready_o, .q_ready_i(q_ready), .q_valid_o(q_valid), .q_count_o(q_count),
    .q_kind_o(q_kind), .q_start_o(q_start), .q_len_o(q_len), .q_line_o(q_line)
  );

  tls_back #(.LengthBits(LENGTH_BITS), .PositionBits(POSITION_BITS)) u_back (
    .clk_i, .rst_ni, .push_i(q_valid), .count_i(q_count), .kind_i(q_kind),
    .start_i(q_start), .len_i(q_len), .line_i(q_line), .ready_o(q_ready),
    .valid_o, .ready_i, .kind_o(token_kind_o), .start_o(token_start_o),
    .len_o(token_length_o), .line_o(token_line_o), .last_o
  );

  `TLS_ASSERT(a_eof_last, valid_o && token_kind_o == tls_pkg::KEof |-> last_o, "eof not last")
  `TLS_ASSERT(a_end_gives_token, valid_i && ready_o && end_of_source_i |=> valid_o, "no eof")
  `TLS_ASSERT(a_kind_range, valid_o |-> token_kind_o <= tls_pkg::KEof, "bad kind")
endmodule
